>>> rtl/pcsa_pkg.sv
// Package for the PCSA cardinality estimator: field widths, reset values
// and default parameter values shared by the RTL.
// No dependencies.
package pcsa_pkg;

  localparam int HASH_W          = 64;
  localparam int SCALE_W         = 16;
  localparam int EST_W           = 40;
  localparam int SUM_W           = 12;
  localparam int RUN_W           = 6;
  localparam int FRAC_W          = 8;
  localparam int SHIFT_MAX       = 48;
  localparam int RECIP_FRAC      = 24;

  localparam int BUCKETS_DEF     = 64;
  localparam int BITMAP_BITS_DEF = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd21181;
  localparam logic [SUM_W-1:0]   SUM_MAX     = 12'd4095;
  localparam logic [EST_W-1:0]   EST_MAX     = {EST_W{1'b1}};

endpackage

>>> rtl/pcsa_cardinality_estimator_top.sv
// PCSA cardinality estimator, top level: bucket bitmap memory, run and sum
// update and estimate calculation in a three-stage pipeline.
// Depends on pcsa_pkg.
//
// How the block is used.
// Each input item is one 64-bit hash on hash_word, offered with in_valid and
// taken at a rising edge where in_valid is high and in_stall is low. The low
// bits of the hash pick a bucket; the first set bit found from bit 63 picks
// a position in that bucket's bitmap. Every item gives exactly one result
// item on estimate and run_sum, offered with out_valid and taken at an edge
// where out_stall is low.
// A taken hash passes the read, sum and result registers before out_valid
// rises. Throughput is one item per cycle unless stalled, set by the bitmap
// memory, which is read once and written once per cycle; a write to the same
// bucket as the item being read is forwarded into the read register. While a
// result waits on a stalled receiver the whole pipeline holds and in_stall is
// raised; nothing is lost or repeated. The scale register is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, which the block does not enforce. Reset (rst, synchronous) clears the
// pipeline, the running sum and the per-bucket valid bits, so every bucket
// reads as an empty bitmap afterwards; scale returns to its default.
module pcsa_cardinality_estimator_top #(
  parameter int BUCKETS     = pcsa_pkg::BUCKETS_DEF,
  parameter int BITMAP_BITS = pcsa_pkg::BITMAP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pcsa_pkg::SCALE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pcsa_pkg::HASH_W-1:0] hash_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcsa_pkg::EST_W-1:0]  estimate,
  output logic [pcsa_pkg::SUM_W-1:0]  run_sum
);

  // Bucket index width, and how many hash bits from the top can reach a
  // bitmap position without running into the bucket index.
  localparam int IW     = $clog2(BUCKETS);
  localparam int SPAN   = pcsa_pkg::HASH_W - IW;
  localparam int PW     = (BITMAP_BITS < SPAN) ? BITMAP_BITS : SPAN;
  localparam int WORD_W = pcsa_pkg::RUN_W + BITMAP_BITS;
  localparam int PROD_W = pcsa_pkg::SUM_W + pcsa_pkg::RECIP_FRAC;
  // Reciprocal of the bucket count; exact for every sum that fits SUM_W.
  localparam longint RECIP = ((64'd1 << pcsa_pkg::RECIP_FRAC) + BUCKETS - 1) / BUCKETS;

  // The pipeline moves as one: it holds only while a result is refused.
  logic hold;
  logic accept;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // Scale register.
  logic [pcsa_pkg::SCALE_W-1:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= pcsa_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale <= cfg_wr_data;
    end
  end

  // Bitmap memory. Each word holds the run length above the bitmap. A valid
  // bit per bucket stands in for clearing the memory at reset.
  logic [WORD_W-1:0]  mem [BUCKETS];
  logic [BUCKETS-1:0] mem_vld;

  logic [IW-1:0]     in_bucket;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;

  assign in_bucket = hash_word[IW-1:0];

  // Stage one: the accepted hash and the bucket word as read.
  logic                        s1_valid;
  logic [pcsa_pkg::HASH_W-1:0] s1_hash;
  logic [WORD_W-1:0]           rd_word;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_hash[IW-1:0]] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_hash <= hash_word;
      if (wr_en && (s1_hash[IW-1:0] == in_bucket)) begin
        rd_word <= wr_word;
        rd_vld  <= 1'b1;
      end else begin
        rd_word <= mem[in_bucket];
        rd_vld  <= mem_vld[in_bucket];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (wr_en) begin
      mem_vld[s1_hash[IW-1:0]] <= 1'b1;
    end
  end

  // Stage one logic: find the position, update the bitmap, its run and the
  // running sum.
  logic                        in_range;
  logic [PW-1:0]               top_bits;
  logic [PW-1:0]               first_set;
  logic                        found;
  logic                        update;
  logic [BITMAP_BITS-1:0]      old_bits;
  logic [pcsa_pkg::RUN_W-1:0]  old_run;
  logic [BITMAP_BITS-1:0]      new_bits;
  logic [BITMAP_BITS-1:0]      zeros;
  logic [BITMAP_BITS-1:0]      lowest_zero;
  logic [pcsa_pkg::RUN_W-1:0]  new_run;
  logic [pcsa_pkg::SUM_W:0]    sum_wide;
  logic [pcsa_pkg::SUM_W-1:0]  sum_next;
  logic [pcsa_pkg::SUM_W-1:0]  total_sum;

  always_comb begin
    in_range = ({1'b0, s1_hash[IW-1:0]} < (IW + 1)'(BUCKETS));
    for (int j = 0; j < PW; j++) begin
      top_bits[j] = s1_hash[pcsa_pkg::HASH_W-1-j];
    end
    // Position zero is bit 63, so the first set bit is the lowest one here.
    first_set = top_bits & (~top_bits + PW'(1));
    found     = |top_bits;
    update    = s1_valid && in_range && found;

    old_bits = rd_vld ? rd_word[BITMAP_BITS-1:0] : '0;
    old_run  = rd_vld ? rd_word[WORD_W-1:BITMAP_BITS] : '0;
    new_bits = old_bits | BITMAP_BITS'(first_set);

    // Run of ones from bit 0 ends at the lowest clear bit.
    zeros       = ~new_bits;
    lowest_zero = zeros & (~zeros + BITMAP_BITS'(1));
    new_run     = (lowest_zero == '0) ? pcsa_pkg::RUN_W'(BITMAP_BITS) : '0;
    for (int i = 0; i < BITMAP_BITS; i++) begin
      if (lowest_zero[i]) begin
        new_run = new_run | pcsa_pkg::RUN_W'(i);
      end
    end

    if (total_sum < pcsa_pkg::SUM_W'(old_run)) begin
      sum_wide = (pcsa_pkg::SUM_W + 1)'(new_run);
    end else begin
      sum_wide = {1'b0, total_sum} - (pcsa_pkg::SUM_W + 1)'(old_run)
               + (pcsa_pkg::SUM_W + 1)'(new_run);
    end
    if (sum_wide > {1'b0, pcsa_pkg::SUM_MAX}) begin
      sum_next = pcsa_pkg::SUM_MAX;
    end else begin
      sum_next = sum_wide[pcsa_pkg::SUM_W-1:0];
    end
    if (!update) begin
      sum_next = total_sum;
    end
  end

  assign wr_en   = update && !hold;
  assign wr_word = {new_run, new_bits};

  // Stage two: total_sum itself holds the sum for the item in this stage.
  logic s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      total_sum <= '0;
    end else if (!hold) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      if (s1_valid) begin
        total_sum <= sum_next;
      end
    end
  end

  // Stage two logic: the exponent is sum divided by the bucket count, done
  // as a multiplication by the reciprocal, then scale is shifted by it.
  logic [PROD_W-1:0]               prod;
  logic [pcsa_pkg::SUM_W-1:0]      shift_amt;
  logic [pcsa_pkg::HASH_W-1:0]     shifted;
  logic [pcsa_pkg::EST_W-1:0]      est_next;

  always_comb begin
    prod      = PROD_W'(total_sum) * PROD_W'(RECIP);
    shift_amt = prod[PROD_W-1:pcsa_pkg::RECIP_FRAC];
    shifted   = pcsa_pkg::HASH_W'(scale) << shift_amt[5:0];
    if (shift_amt > pcsa_pkg::SUM_W'(pcsa_pkg::SHIFT_MAX)) begin
      est_next = (scale != '0) ? pcsa_pkg::EST_MAX : '0;
    end else if (|shifted[pcsa_pkg::HASH_W-1:pcsa_pkg::EST_W+pcsa_pkg::FRAC_W]) begin
      est_next = pcsa_pkg::EST_MAX;
    end else begin
      est_next = shifted[pcsa_pkg::EST_W+pcsa_pkg::FRAC_W-1:pcsa_pkg::FRAC_W];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!hold) begin
      estimate <= est_next;
      run_sum  <= total_sum;
    end
  end

`ifndef SYNTH
  // The running sum can never pass what all buckets together can hold.
  a_sum_bound : assert property (@(posedge clk) disable iff (rst)
    (32'(total_sum) <= BUCKETS * BITMAP_BITS) || (total_sum == pcsa_pkg::SUM_MAX))
    else $error("running sum beyond the bucket capacity");

  // Bits are only ever added, so a bucket's run cannot shrink.
  a_run_grows : assert property (@(posedge clk) disable iff (rst)
    update |-> (new_run >= old_run))
    else $error("bucket run length decreased");

  // A write to the bucket being read must reach the read register.
  a_forward : assert property (@(posedge clk) disable iff (rst)
    (wr_en && accept && (s1_hash[IW-1:0] == in_bucket)) |=>
      (rd_vld && (rd_word == $past(wr_word))))
    else $error("bucket write not forwarded to a following read");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for pcsa_cardinality_estimator_top: directed hash table, then random
// hash streams with scale changes between phases, checked against a predictor of the bucket maps.
// Depends on pcsa_pkg and the RTL of the estimator; needs no other files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block as built with its default parameters.
  localparam int NUM_BUCKETS = pcsa_pkg::BUCKETS_DEF;
  localparam int MAP_BITS    = pcsa_pkg::BITMAP_BITS_DEF;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int SEARCH_SPAN = pcsa_pkg::HASH_W - IDX_W;
  localparam int IDLE_PCT    = 23;
  localparam int PHASE_ITEMS = 175;
  localparam int PHASES      = 4;

  // Kinds of random hash. Most are well-formed hits on a bitmap position; the rest are noise
  // and the cases that leave the state untouched.
  typedef enum int {
    HASH_HIT,
    HASH_ANY,
    HASH_NO_BIT,
    HASH_TOO_DEEP
  } hash_kind_t;

  // One result item as the block presents it.
  typedef struct packed {
    logic [pcsa_pkg::EST_W-1:0] est_val;
    logic [pcsa_pkg::SUM_W-1:0] run_total;
  } result_t;

  // One row of the directed table. Where known is set, the result is typed in by hand and is
  // queued in place of the predicted one; the predictor still tracks the state either way.
  typedef struct packed {
    logic [pcsa_pkg::HASH_W-1:0] hash;
    logic                        known;
    result_t                     want;
  } hash_row_t;

  localparam int DIRECTED_ROWS = 17;

  // With the reset scale of 21181 and a run sum below 64 the estimate is 21181 >> 8 = 82.
  hash_row_t directed_rows [DIRECTED_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, '{40'd82, 12'd0}},  // no set bit at all, bucket 0
    '{64'h0000_0000_0000_003F, 1'b1, '{40'd82, 12'd0}},  // only the bucket bits, bucket 63
    '{64'h0000_0000_FFFF_FFFF, 1'b1, '{40'd82, 12'd0}},  // first set bit at position 32
    '{64'h8000_0000_0000_0000, 1'b1, '{40'd82, 12'd1}},  // bucket 0, position 0
    '{64'h8000_0000_0000_0000, 1'b1, '{40'd82, 12'd1}},  // the same hash again
    '{64'h0000_0001_0000_0000, 1'b1, '{40'd82, 12'd1}},  // deepest position, 31, leaves a gap
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{40'd82, 12'd2}},  // all ones: bucket 63, position 0
    '{64'h4000_0000_0000_0001, 1'b1, '{40'd82, 12'd2}},  // bucket 1, position 1 before 0
    '{64'h8000_0000_0000_0001, 1'b1, '{40'd82, 12'd4}},  // fills the gap, run of two
    '{64'h2000_0000_0000_0001, 1'b1, '{40'd82, 12'd5}},  // run of three
    '{64'h0000_0002_0000_0000, 1'b1, '{40'd82, 12'd5}},  // position 30 in bucket 0
    '{64'h4000_0000_0000_0000, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'h0000_0000_8000_0000, 1'b0, '0},
    '{64'h0000_0000_0000_0040, 1'b0, '0},
    '{64'h1000_0000_0000_003F, 1'b0, '0}
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [pcsa_pkg::SCALE_W-1:0]  cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [pcsa_pkg::HASH_W-1:0]   hash_word;
  logic                          out_valid;
  logic                          out_stall;
  logic [pcsa_pkg::EST_W-1:0]    estimate;
  logic [pcsa_pkg::SUM_W-1:0]    run_sum;

  // The predictor's own copy of the block's state and of the scale register.
  logic [MAP_BITS-1:0]           bucket_maps [NUM_BUCKETS];
  logic [pcsa_pkg::RUN_W-1:0]    bucket_runs [NUM_BUCKETS];
  logic [pcsa_pkg::SUM_W-1:0]    sum_of_runs;
  logic [pcsa_pkg::SCALE_W-1:0]  scale_now;

  // Results still owed by the block, oldest first.
  result_t             owed_estimates [$];

  // Handed from the sender to the acceptance monitor along with the hash on offer.
  logic                offer_known;
  result_t             offer_want;

  // Set for a stretch of the random part in which neither side idles.
  bit                  steady;
  bit                  board_failed;
  int                  sent_random;

  pcsa_cardinality_estimator_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hash_word  (hash_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .estimate   (estimate),
    .run_sum    (run_sum)
  );

  always #4 clk = ~clk;

  // Folds one hash into the predicted state and returns the result the block should give.
  // The position is the count of leading zeros from bit 63 over the bits above the bucket
  // index; positions past the bitmap, and hashes with no set bit, leave the state alone.
  function automatic result_t absorb_hash(input logic [pcsa_pkg::HASH_W-1:0] h);
    int                    pos;
    int                    old_run;
    int                    new_run;
    int                    new_sum;
    int                    shift;
    logic [IDX_W-1:0]      bkt;
    logic [63:0]           wide;
    result_t               res;
    pos = -1;
    bkt = h[IDX_W-1:0];
    for (int k = 0; k < SEARCH_SPAN; k++) begin
      if (pos < 0 && h[pcsa_pkg::HASH_W-1-k]) begin
        pos = k;
      end
    end
    if (pos >= 0 && pos < MAP_BITS) begin
      bucket_maps[bkt][pos] = 1'b1;
      old_run = bucket_runs[bkt];
      new_run = 0;
      while (new_run < MAP_BITS && bucket_maps[bkt][new_run]) begin
        new_run++;
      end
      bucket_runs[bkt] = pcsa_pkg::RUN_W'(new_run);
      new_sum = int'(sum_of_runs) - old_run + new_run;
      if (int'(sum_of_runs) < old_run) begin
        new_sum = new_run;
      end
      sum_of_runs = (new_sum > int'(pcsa_pkg::SUM_MAX)) ? pcsa_pkg::SUM_MAX
                                                        : pcsa_pkg::SUM_W'(new_sum);
    end
    // Estimate: scale shifted up by whole multiples of the bucket count, fraction dropped.
    shift = int'(sum_of_runs) / NUM_BUCKETS;
    if (shift > pcsa_pkg::SHIFT_MAX) begin
      wide = (scale_now != '0) ? 64'(pcsa_pkg::EST_MAX) : 64'd0;
    end else begin
      wide = (64'(scale_now) << shift) >> pcsa_pkg::FRAC_W;
    end
    if (wide > 64'(pcsa_pkg::EST_MAX)) begin
      wide = 64'(pcsa_pkg::EST_MAX);
    end
    res.est_val   = wide[pcsa_pkg::EST_W-1:0];
    res.run_total = sum_of_runs;
    return res;
  endfunction

  // Builds a random hash of the given kind. Hits favour a few buckets and the position just
  // past the bucket's current run, so runs grow long and some bitmaps fill completely.
  function automatic logic [pcsa_pkg::HASH_W-1:0] random_hash(input hash_kind_t kind);
    logic [pcsa_pkg::HASH_W-1:0] h;
    logic [pcsa_pkg::HASH_W-1:0] below;
    logic [IDX_W-1:0]            bkt;
    int                          pos;
    bkt = ($urandom_range(1) == 1) ? IDX_W'($urandom_range(7))
                                   : IDX_W'($urandom_range(NUM_BUCKETS - 1));
    case (kind)
      HASH_HIT: begin
        if ($urandom_range(99) < 60 && bucket_runs[bkt] < MAP_BITS) begin
          pos = bucket_runs[bkt];
        end else begin
          pos = $urandom_range(MAP_BITS - 1);
        end
      end
      HASH_TOO_DEEP: begin
        pos = $urandom_range(SEARCH_SPAN - 1, MAP_BITS);
      end
      default: begin
        pos = -1;
      end
    endcase
    if (kind == HASH_ANY) begin
      h = {$urandom, $urandom};
    end else if (pos < 0) begin
      h = '0;
    end else begin
      // A single leading one at the chosen position, random bits below it.
      below = (64'd1 << (pcsa_pkg::HASH_W - 1 - pos)) - 64'd1;
      h = (64'd1 << (pcsa_pkg::HASH_W - 1 - pos)) | ({$urandom, $urandom} & below);
    end
    h[IDX_W-1:0] = bkt;
    return h;
  endfunction

  // Offers one hash and returns just after the edge at which the block takes it. Random idle
  // cycles come first, each decided at a falling edge, unless the steady stretch is running.
  task automatic offer_hash(input logic [pcsa_pkg::HASH_W-1:0] h, input logic known,
                            input result_t want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    hash_word   <= h;
    offer_known = known;
    offer_want  = want;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Lets every owed result drain, then writes the scale register while the block is idle.
  task automatic write_scale(input logic [pcsa_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_estimates.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    scale_now   = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // The receiver stalls at random, decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= !steady && !rst && ($urandom_range(99) < IDLE_PCT);
  end

  // Both handshakes are observed at the rising edge. An accepted hash queues its result at
  // once; an accepted result is checked against the oldest one owed.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = absorb_hash(hash_word);
        owed_estimates.push_back(offer_known ? offer_want : want);
      end
      if (out_valid && !out_stall) begin
        got.est_val   = estimate;
        got.run_total = run_sum;
        if (owed_estimates.size() == 0) begin
          $error("result with no hash owing one: estimate %0d, run_sum %0d",
                 estimate, run_sum);
          board_failed = 1'b1;
        end else begin
          want = owed_estimates.pop_front();
          if (got.est_val !== want.est_val) begin
            $error("estimate: expected %0d, got %0d", want.est_val, got.est_val);
            board_failed = 1'b1;
          end
          if (got.run_total !== want.run_total) begin
            $error("run_sum: expected %0d, got %0d", want.run_total, got.run_total);
            board_failed = 1'b1;
          end
        end
      end
    end
  end

  // Guard against a hung handshake: far longer than the slowest correct run needs.
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [pcsa_pkg::SCALE_W-1:0] phase_scale [PHASES];
    hash_kind_t                   kind;
    int                           roll;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    hash_word    = '0;
    out_stall    = 1'b0;
    offer_known  = 1'b0;
    offer_want   = '0;
    steady       = 1'b0;
    board_failed = 1'b0;
    sent_random  = 0;

    // Predicted state after reset: empty bitmaps, zero runs and sum, default scale.
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      bucket_maps[b] = '0;
      bucket_runs[b] = '0;
    end
    sum_of_runs = '0;
    scale_now   = pcsa_pkg::SCALE_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset scale.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_hash(directed_rows[r].hash, directed_rows[r].known, directed_rows[r].want);
    end

    // Random part in phases: largest scale, smallest nonzero, a random one, then the default
    // once more. The bitmaps keep filling across phases, so later phases see larger shifts.
    phase_scale[0] = '1;
    phase_scale[1] = pcsa_pkg::SCALE_W'(1);
    phase_scale[2] = pcsa_pkg::SCALE_W'($urandom_range(65535, 1));
    phase_scale[3] = pcsa_pkg::SCALE_RESET;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_scale(phase_scale[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        steady = (sent_random >= 180 && sent_random < 300);
        roll = $urandom_range(99);
        if (roll < 75) begin
          kind = HASH_HIT;
        end else if (roll < 85) begin
          kind = HASH_ANY;
        end else if (roll < 90) begin
          kind = HASH_NO_BIT;
        end else begin
          kind = HASH_TOO_DEEP;
        end
        offer_hash(random_hash(kind), 1'b0, '0);
        sent_random++;
      end
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_estimates.size() != 0) begin
      @(posedge clk);
    end
    // Keep watching so that any result the block should not have given is caught.
    repeat (8) @(posedge clk);

    if (!board_failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
